FILE: design/eyvm_pkg.sv
// ----------------------------------------------------------------------------
// eyvm_pkg
// Shared constants, types and helpers of the Y-X-Z view matrix core.
// ----------------------------------------------------------------------------
package eyvm_pkg;

  localparam int SINCOS_ITERATIONS = 16;
  localparam int BASIS_FRAC_BITS   = 14;
  localparam int MAX_STEPS         = 24;
  localparam int STEPS = (SINCOS_ITERATIONS > MAX_STEPS) ? MAX_STEPS : SINCOS_ITERATIONS;
  localparam int BSH   = 30 - BASIS_FRAC_BITS;

  // Q3.28 angle constants and CORDIC gain in Q2.30
  localparam logic signed [33:0] ANG_PI      = 34'sd843314857;
  localparam logic signed [33:0] ANG_HALF_PI = 34'sd421657428;
  localparam logic signed [33:0] ANG_TWO_PI  = 34'sd1686629713;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

  // Arctangent table in Q3.28
  function automatic logic signed [33:0] atan_lut(input int i);
    logic signed [33:0] r;
    case (i)
      0: r = 34'sd210828714;  1: r = 34'sd124459457;  2: r = 34'sd65760959;
      3: r = 34'sd33381290;   4: r = 34'sd16755422;   5: r = 34'sd8385879;
      6: r = 34'sd4193963;    7: r = 34'sd2097109;    8: r = 34'sd1048571;
      9: r = 34'sd524287;     10: r = 34'sd262144;    11: r = 34'sd131072;
      12: r = 34'sd65536;     13: r = 34'sd32768;     14: r = 34'sd16384;
      15: r = 34'sd8192;      16: r = 34'sd4096;      17: r = 34'sd2048;
      18: r = 34'sd1024;      19: r = 34'sd512;       20: r = 34'sd256;
      21: r = 34'sd128;       22: r = 34'sd64;        23: r = 34'sd32;
      default: r = '0;
    endcase
    return r;
  endfunction

  // Q2.30 product rounded back to Q2.30
  function automatic logic signed [33:0] mul30(input logic signed [33:0] a,
                                               input logic signed [33:0] b);
    logic signed [67:0] p;
    p = a * b + (68'sd1 <<< 29);
    return 34'(p >>> 30);
  endfunction

  // Q2.30 to basis format with saturation
  function automatic logic signed [15:0] to_basis(input logic signed [35:0] v);
    logic signed [35:0] r;
    logic signed [35:0] one;
    logic signed [35:0] lo;
    logic signed [35:0] hi;
    one = 36'sd1 <<< BASIS_FRAC_BITS;
    r = (BSH > 0) ? ((v + (36'sd1 <<< ((BSH > 0) ? BSH - 1 : 0))) >>> BSH) : v;
    lo = (one > 36'sd32768) ? -36'sd32768 : -one;
    hi = (one > 36'sd32767) ? 36'sd32767 : one;
    if (r < lo) r = lo;
    if (r > hi) r = hi;
    return r[15:0];
  endfunction

  typedef struct packed {
    logic signed [33:0] s1, c1, s2, c2, s3, c3;
  } trig_t;

  typedef struct packed {
    logic signed [15:0] b0, b1, b2, b3, b4, b5, b6, b7, b8;
  } basis_t;

  typedef struct packed {
    logic signed [31:0] px, py, pz;
  } pos_t;

endpackage

FILE: design/eyvm_cordic.sv
// ----------------------------------------------------------------------------
// eyvm_cordic
// Pipelined sine/cosine: range reduction stage then one CORDIC step per stage.
// ----------------------------------------------------------------------------
module eyvm_cordic import eyvm_pkg::*; (
  input  logic                clk,
  input  logic                en,
  input  logic signed [15:0]  angle,
  output logic signed [33:0]  sin_q,
  output logic signed [33:0]  cos_q
);

  logic signed [33:0] x [0:STEPS];
  logic signed [33:0] y [0:STEPS];
  logic signed [33:0] z [0:STEPS];
  logic               ng [0:STEPS];
  logic signed [33:0] z0;
  logic signed [33:0] z1;
  logic               n0;

  // Wrap to (-pi, pi] then fold to [-pi/2, pi/2]
  always_comb begin
    z0 = 34'(angle) <<< 16;
    if (z0 > ANG_PI) z0 = z0 - ANG_TWO_PI;
    else if (z0 < -ANG_PI) z0 = z0 + ANG_TWO_PI;
    n0 = 1'b0;
    z1 = z0;
    if (z0 > ANG_HALF_PI) begin
      z1 = z0 - ANG_PI;
      n0 = 1'b1;
    end else if (z0 < -ANG_HALF_PI) begin
      z1 = z0 + ANG_PI;
      n0 = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x[0] <= CORDIC_GAIN;
      y[0] <= '0;
      z[0] <= z1;
      ng[0] <= n0;
    end
  end

  // One rotation per stage
  for (genvar i = 0; i < STEPS; i++) begin : g_step
    always_ff @(posedge clk) begin
      if (en) begin
        if (z[i] >= 0) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - atan_lut(i);
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + atan_lut(i);
        end
        ng[i+1] <= ng[i];
      end
    end
  end

  assign sin_q = ng[STEPS] ? -y[STEPS] : y[STEPS];
  assign cos_q = ng[STEPS] ? -x[STEPS] : x[STEPS];

endmodule

FILE: design/eyvm_basis.sv
// ----------------------------------------------------------------------------
// eyvm_basis
// Three-stage product tree forming the rounded, saturated view basis.
// ----------------------------------------------------------------------------
module eyvm_basis import eyvm_pkg::*; (
  input  logic   clk,
  input  logic   en,
  input  trig_t  t,
  output basis_t b
);

  trig_t              t1;
  logic signed [33:0] s1s2, c1c3, c1s2, c2s3, c3s1, c1s3, c2c3, s1s3, c2s1, c1c2;
  logic signed [33:0] r0, r2, r3, r5;
  logic signed [33:0] k0, k1, k2, k3, k4, k5, k6, k7, k8;

  // Stage 1: pair products
  always_ff @(posedge clk) begin
    if (en) begin
      t1   <= t;
      s1s2 <= mul30(t.s1, t.s2);
      c1c3 <= mul30(t.c1, t.c3);
      c1s2 <= mul30(t.c1, t.s2);
      c2s3 <= mul30(t.c2, t.s3);
      c3s1 <= mul30(t.c3, t.s1);
      c1s3 <= mul30(t.c1, t.s3);
      c2c3 <= mul30(t.c2, t.c3);
      s1s3 <= mul30(t.s1, t.s3);
      c2s1 <= mul30(t.c2, t.s1);
      c1c2 <= mul30(t.c1, t.c2);
    end
  end

  // Stage 2: triple products, carry the rest
  always_ff @(posedge clk) begin
    if (en) begin
      r0 <= mul30(s1s2, t1.s3);
      r2 <= mul30(c1s2, t1.s3);
      r3 <= mul30(s1s2, t1.c3);
      r5 <= mul30(c1c3, t1.s2);
      k0 <= c1c3; k1 <= c2s3; k2 <= c3s1; k3 <= c1s3; k4 <= c2c3;
      k5 <= s1s3; k6 <= c2s1; k7 <= -t1.s2; k8 <= c1c2;
    end
  end

  // Stage 3: sums, rounding and saturation
  always_ff @(posedge clk) begin
    if (en) begin
      b.b0 <= to_basis(36'(k0) + 36'(r0));
      b.b1 <= to_basis(36'(k1));
      b.b2 <= to_basis(36'(r2) - 36'(k2));
      b.b3 <= to_basis(36'(r3) - 36'(k3));
      b.b4 <= to_basis(36'(k4));
      b.b5 <= to_basis(36'(r5) + 36'(k5));
      b.b6 <= to_basis(36'(k6));
      b.b7 <= to_basis(36'(k7));
      b.b8 <= to_basis(36'(k8));
    end
  end

endmodule

FILE: design/eyvm_trans.sv
// ----------------------------------------------------------------------------
// eyvm_trans
// Two-stage dot products of basis rows with the position, negated and saturated.
// ----------------------------------------------------------------------------
module eyvm_trans import eyvm_pkg::*; (
  input  logic               clk,
  input  logic               en,
  input  basis_t             b,
  input  pos_t               p,
  output basis_t             bo,
  output logic signed [31:0] tx,
  output logic signed [31:0] ty,
  output logic signed [31:0] tz
);

  logic signed [47:0] m [0:8];
  basis_t             b1;

  function automatic logic signed [31:0] fin(input logic signed [47:0] a0,
                                             input logic signed [47:0] a1,
                                             input logic signed [47:0] a2);
    logic signed [51:0] acc;
    acc = -(52'(a0) + 52'(a1) + 52'(a2));
    acc = (acc + (52'sd1 <<< (BASIS_FRAC_BITS - 1))) >>> BASIS_FRAC_BITS;
    if (acc < -52'sd2147483648) acc = -52'sd2147483648;
    if (acc > 52'sd2147483647) acc = 52'sd2147483647;
    return acc[31:0];
  endfunction

  // Stage 1: nine products
  always_ff @(posedge clk) begin
    if (en) begin
      b1   <= b;
      m[0] <= b.b0 * p.px; m[1] <= b.b1 * p.py; m[2] <= b.b2 * p.pz;
      m[3] <= b.b3 * p.px; m[4] <= b.b4 * p.py; m[5] <= b.b5 * p.pz;
      m[6] <= b.b6 * p.px; m[7] <= b.b7 * p.py; m[8] <= b.b8 * p.pz;
    end
  end

  // Stage 2: sum, round, saturate
  always_ff @(posedge clk) begin
    if (en) begin
      bo <= b1;
      tx <= fin(m[0], m[1], m[2]);
      ty <= fin(m[3], m[4], m[5]);
      tz <= fin(m[6], m[7], m[8]);
    end
  end

endmodule

FILE: design/euler_yxz_view_matrix_core.sv
// ----------------------------------------------------------------------------
// euler_yxz_view_matrix_core
// Y-X-Z Euler view basis and translation, fully pipelined.
// ----------------------------------------------------------------------------
// One transaction is accepted per cycle while the output is not stalled. The
// stages are one reduction stage and one stage per CORDIC step, three
// basis product stages, two translation stages. The whole pipeline advances
// together; a stall of m_tready holds every stage, so the rate is set by the
// downstream consumer alone.
module euler_yxz_view_matrix_core import eyvm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // pos_x[31:0], pos_y[63:32], pos_z[95:64], angle_x[111:96],
  // angle_y[127:112], angle_z[143:128]
  input  logic [143:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // right_x, right_y, right_z, up_x, up_y, up_z, fwd_x, fwd_y, fwd_z (16 each,
  // [143:0]), trans_x[175:144], trans_y[207:176], trans_z[239:208]
  output logic [239:0] m_tdata
);

  localparam int LAT = STEPS + 6;

  logic               en;
  logic [LAT-1:0]     vld;
  pos_t               pq [0:STEPS+3];
  wire trig_t         tg;
  basis_t             bs;
  basis_t             bo;
  logic signed [31:0] tx, ty, tz;

  // Advance when the output slot is free or being taken
  assign en       = !m_tvalid || m_tready;
  assign s_tready = en;
  assign m_tvalid = vld[LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // Position delay line up to the translation stage
  always_ff @(posedge clk) begin
    if (en) begin
      pq[0] <= '{px: s_tdata[31:0], py: s_tdata[63:32], pz: s_tdata[95:64]};
      for (int i = 1; i <= STEPS + 3; i++) pq[i] <= pq[i-1];
    end
  end

  eyvm_cordic u_c1 (.clk, .en, .angle(s_tdata[127:112]), .sin_q(tg.s1), .cos_q(tg.c1));
  eyvm_cordic u_c2 (.clk, .en, .angle(s_tdata[111:96]),  .sin_q(tg.s2), .cos_q(tg.c2));
  eyvm_cordic u_c3 (.clk, .en, .angle(s_tdata[143:128]), .sin_q(tg.s3), .cos_q(tg.c3));

  eyvm_basis u_basis (.clk, .en, .t(tg), .b(bs));

  eyvm_trans u_trans (.clk, .en, .b(bs), .p(pq[STEPS+3]), .bo, .tx, .ty, .tz);

  assign m_tdata = {tz, ty, tx, bo.b8, bo.b7, bo.b6, bo.b5, bo.b4, bo.b3,
                    bo.b2, bo.b1, bo.b0};

`ifndef SYNTH
  // Stalled output holds its valid and data
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output changed under stall");
  // An input accepted while the output is free is registered into the first valid stage
  a_lat: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && m_tready |=> vld[0])
    else $error("accepted transaction lost");
  // Input is ready whenever the output is empty
  a_rdy: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("ready low with empty output");
`endif

endmodule

FILE: bench/euler_yxz_view_matrix_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// euler_yxz_view_matrix_checker
// Predicts the view basis and translation of every accepted input transaction
// and compares each output transaction, field by field, with the oldest one.
// ----------------------------------------------------------------------------
module euler_yxz_view_matrix_checker import eyvm_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  input  logic         s_tready,
  input  logic [143:0] s_tdata,
  input  logic         m_tvalid,
  input  logic         m_tready,
  input  logic [239:0] m_tdata,
  output int           fail_count,
  output int           pending
);

  typedef logic signed [63:0] w64_t;

  logic [239:0] view_q[$];

  function automatic w64_t floor_shift(input w64_t v, input int s);
    return v >>> s;
  endfunction

  function automatic w64_t q30_mul(input w64_t a, input w64_t b);
    return floor_shift(a * b + (w64_t'(1) <<< 29), 30);
  endfunction

  // CORDIC sine and cosine of a Q4.12 angle, both Q2.30
  function automatic void angle_sincos(input logic signed [15:0] ang, output w64_t sn,
                                       output w64_t cs);
    w64_t z, x, y, nx, atab[24];
    logic flip;
    int n;
    atab = '{210828714, 124459457, 65760959, 33381290, 16755422, 8385879,
             4193963, 2097109, 1048571, 524287, 262144, 131072,
             65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};
    z = w64_t'(ang) * 65536;
    x = 652032874;
    y = 0;
    flip = 1'b0;
    n = (SINCOS_ITERATIONS > 24) ? 24 : SINCOS_ITERATIONS;
    if (z > 843314857) z = z - 1686629713;
    else if (z < -843314857) z = z + 1686629713;
    if (z > 421657428) begin
      z = z - 843314857;
      flip = 1'b1;
    end else if (z < -421657428) begin
      z = z + 843314857;
      flip = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      if (z >= 0) begin
        nx = x - floor_shift(y, i);
        y = y + floor_shift(x, i);
        z = z - atab[i];
      end else begin
        nx = x + floor_shift(y, i);
        y = y - floor_shift(x, i);
        z = z + atab[i];
      end
      x = nx;
    end
    sn = flip ? -y : y;
    cs = flip ? -x : x;
  endfunction

  function automatic w64_t basis_round(input w64_t v);
    w64_t r, unit;
    int sh;
    sh = 30 - BASIS_FRAC_BITS;
    unit = w64_t'(1) <<< BASIS_FRAC_BITS;
    r = (sh > 0) ? floor_shift(v + (w64_t'(1) <<< (sh - 1)), sh) : v;
    if (r < -unit) r = -unit;
    if (r > unit) r = unit;
    if (r < -32768) r = -32768;
    if (r > 32767) r = 32767;
    return r;
  endfunction

  function automatic logic [31:0] neg_dot(input w64_t a, input w64_t b, input w64_t c,
                                          input w64_t px, input w64_t py, input w64_t pz);
    w64_t acc;
    acc = -(a * px + b * py + c * pz);
    acc = floor_shift(acc + (w64_t'(1) <<< (BASIS_FRAC_BITS - 1)), BASIS_FRAC_BITS);
    if (acc < -64'sd2147483648) acc = -64'sd2147483648;
    if (acc > 64'sd2147483647) acc = 64'sd2147483647;
    return acc[31:0];
  endfunction

  function automatic logic [239:0] predict_view(input logic [143:0] d);
    w64_t px, py, pz, s1, c1, s2, c2, s3, c3, s1s2, c1c3, b[9];
    logic [239:0] r;
    px = w64_t'(signed'(d[31:0]));
    py = w64_t'(signed'(d[63:32]));
    pz = w64_t'(signed'(d[95:64]));
    angle_sincos(d[127:112], s1, c1);
    angle_sincos(d[111:96], s2, c2);
    angle_sincos(d[143:128], s3, c3);
    s1s2 = q30_mul(s1, s2);
    c1c3 = q30_mul(c1, c3);
    b[0] = basis_round(c1c3 + q30_mul(s1s2, s3));
    b[1] = basis_round(q30_mul(c2, s3));
    b[2] = basis_round(q30_mul(q30_mul(c1, s2), s3) - q30_mul(c3, s1));
    b[3] = basis_round(q30_mul(s1s2, c3) - q30_mul(c1, s3));
    b[4] = basis_round(q30_mul(c2, c3));
    b[5] = basis_round(q30_mul(c1c3, s2) + q30_mul(s1, s3));
    b[6] = basis_round(q30_mul(c2, s1));
    b[7] = basis_round(-s2);
    b[8] = basis_round(q30_mul(c1, c2));
    for (int k = 0; k < 9; k++) r[16*k +: 16] = b[k][15:0];
    r[175:144] = neg_dot(b[0], b[1], b[2], px, py, pz);
    r[207:176] = neg_dot(b[3], b[4], b[5], px, py, pz);
    r[239:208] = neg_dot(b[6], b[7], b[8], px, py, pz);
    return r;
  endfunction

  initial fail_count = 0;
  assign pending = view_q.size();

  // Predict on input transactions, compare on output transactions
  always @(posedge clk) begin
    logic [239:0] want;
    if (!rst) begin
      if (s_tvalid && s_tready) view_q.push_back(predict_view(s_tdata));
      if (m_tvalid && m_tready) begin
        if (view_q.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("unexpected output %h", m_tdata);
        end else begin
          want = view_q.pop_front();
          for (int f = 0; f < 12; f++) begin
            logic [31:0] e, a;
            e = (f < 9) ? 32'(want[16*f +: 16]) : want[144 + 32*(f-9) +: 32];
            a = (f < 9) ? 32'(m_tdata[16*f +: 16]) : m_tdata[144 + 32*(f-9) +: 32];
            if (e !== a) begin
              fail_count++;
              if (fail_count <= 10)
                $display("field %0d mismatch: expected %h actual %h", f, e, a);
            end
          end
        end
      end
    end
  end

endmodule

FILE: bench/euler_yxz_view_matrix_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// euler_yxz_view_matrix_core_tb
// Drives camera positions and angles into the view matrix core under random
// idling on both sides and back-pressure, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module euler_yxz_view_matrix_core_tb;
  import eyvm_pkg::*;

  localparam int RANDOM_ITEMS = 498;
  localparam int CYCLE_LIMIT  = 200000;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [143:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [239:0] m_tdata;
  int           fail_count;
  int           pending;
  int           send_idle = 24;
  int           recv_idle = 48;
  int           hold_cycles = 0;
  int           cycle_count = 0;

  euler_yxz_view_matrix_core u_top (.*);

  euler_yxz_view_matrix_checker u_chk (.*);

  always #6 clk = ~clk;

  // Stop a hung run
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Receiver: random stall, or a long hold-off when requested
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (hold_cycles > 0) begin
      m_tready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else m_tready <= ($urandom_range(99) >= recv_idle);
  end

  function automatic logic [15:0] pick_angle();
    case ($urandom_range(5))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'($signed($urandom_range(12868)) - 6434);
      3: return 16'($signed($urandom_range(200)) - 100 + 6434 * $urandom_range(1));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [31:0] pick_pos();
    case ($urandom_range(5))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($signed($urandom_range(2000000)) - 1000000);
      default: return $urandom;
    endcase
  endfunction

  // Offer one transaction and wait for its acceptance; valid drops only on idle
  task automatic send_view(input logic [31:0] px, input logic [31:0] py,
                           input logic [31:0] pz, input logic [15:0] ax,
                           input logic [15:0] ay, input logic [15:0] az);
    while ($urandom_range(99) < send_idle) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tdata <= {az, ay, ax, pz, py, px};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    @(negedge clk);
  endtask

  task automatic drain_views();
    s_tvalid <= 1'b0;
    while (pending != 0) @(negedge clk);
  endtask

  initial begin
    logic [15:0] corner_ang[8];
    corner_ang = '{16'h0000, 16'h8000, 16'h7FFF, 16'd6434, 16'hE6DE,
                   16'd12868, 16'd3217, 16'hF36F};
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: angle extremes, quadrant edges, position extremes
    for (int i = 0; i < 8; i++)
      send_view(32'h0001_0000, 32'hFFFF_0000, 32'd0, corner_ang[i],
                corner_ang[(i + 3) % 8], corner_ang[(i + 5) % 8]);
    send_view(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 16'd0, 16'd0, 16'd0);
    send_view(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 16'd0, 16'd0, 16'd0);
    send_view(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'd3217, 16'd3217, 16'd3217);
    send_view(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_view(32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0001, 16'h5555, 16'hAAAA, 16'h1234);

    // Back-pressure: long receiver hold-off while offering continuously
    send_idle = 0;
    hold_cycles = 60;
    for (int i = 0; i < 40; i++)
      send_view(pick_pos(), pick_pos(), pick_pos(), pick_angle(), pick_angle(), pick_angle());
    drain_views();

    for (int phase = 0; phase < 3; phase++) begin
      send_idle = (phase == 0) ? 24 : (phase == 1) ? 48 : 0;
      recv_idle = (phase == 0) ? 48 : (phase == 1) ? 24 : 0;
      for (int i = 0; i < RANDOM_ITEMS / 3; i++)
        send_view(pick_pos(), pick_pos(), pick_pos(), pick_angle(), pick_angle(),
                  pick_angle());
    end

    drain_views();
    repeat (STEPS + 20) @(negedge clk);
    if (fail_count == 0 && pending == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule

FILE: euler_yxz_view_matrix_core.f
design/eyvm_pkg.sv
design/eyvm_cordic.sv
design/eyvm_basis.sv
design/eyvm_trans.sv
design/euler_yxz_view_matrix_core.sv
bench/euler_yxz_view_matrix_checker.sv
bench/euler_yxz_view_matrix_core_tb.sv
